/* hdl/mfbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mfbp_pkg;

    // operation codes on the input tuser
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_ALIGN  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam int OP_W    = 2;
    localparam int WORD_W  = 64;           // value field
    localparam int WIDTH_W = 7;            // field_width field
    localparam int PEND_W  = 7;            // partial byte holds at most seven bits
    localparam int CNT_W   = 3;            // pending bit count
    localparam int BYTE_W  = 8;
    localparam int NB_W    = 4;            // byte count of one run, 0..8
    localparam int ACC_W   = WORD_W + PEND_W;
    localparam int OUT_TOTAL_W = 32;       // bits_written field

    // one run of result bytes handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0] word;           // bytes, first one highest
        logic [NB_W-1:0]   n_bytes;        // 1..8
        logic              byte_valid;
        logic              message_end;
    } t_run;

endpackage
`default_nettype wire

/* hdl/msb_first_bit_packer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake                  payload
// s_axis    in   i_s_axis_tvalid/o_..tready  tdata: value, field_width; tuser: operation
// m_axis    out  o_m_axis_tvalid/i_..tready  tdata: data_byte, bits_written;
//                                            tuser: byte_valid, message_end; tlast
//
// an item is taken each cycle while the run queue has room; an item's result passes
// through the run queue and the output register; the output stage sends one byte per
// cycle while the receiver is ready, so a write of k bytes holds the queue until all k
// are sent and long writes stall the input through the queue
// align with nothing pending and unused operation codes give no result
// synchronous active-low reset clears the pending bits, bit total, queue and output
module msb_first_bit_packer_top #(
    parameter int MAX_FIELD_BITS  = 64,
    parameter int BIT_COUNT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [71:0] i_s_axis_tdata,    // value [63:0], field_width [70:64], zero [71]
    input  wire  [1:0]  i_s_axis_tuser,    // operation [1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,    // data_byte [7:0], bits_written [39:8]
    output logic [1:0]  o_m_axis_tuser,    // byte_valid [0], message_end [1]
    output logic        o_m_axis_tlast     // last_in_run
);

    localparam int RUN_W   = $bits(mfbp_pkg::t_run);
    localparam int ENTRY_W = RUN_W + BIT_COUNT_WIDTH;

    // front to queue
    logic                        front_push;
    mfbp_pkg::t_run              front_run;
    logic [BIT_COUNT_WIDTH-1:0]  front_total;
    logic [ENTRY_W-1:0]          q_in, q_out;
    logic                        q_empty, q_full, q_pop;

    // queue to back
    mfbp_pkg::t_run              head_run;
    logic [BIT_COUNT_WIDTH-1:0]  head_total;

    logic [mfbp_pkg::BYTE_W-1:0]      out_byte;
    logic [mfbp_pkg::OUT_TOTAL_W-1:0] out_bits;
    logic                             out_byte_valid, out_end;

    // front: takes items, keeps the partial byte and total, builds byte runs
    mfbp_front #(
        .MAX_FIELD_BITS  (MAX_FIELD_BITS),
        .BIT_COUNT_WIDTH (BIT_COUNT_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_op         (i_s_axis_tuser),
        .i_value      (i_s_axis_tdata[63:0]),
        .i_width      (i_s_axis_tdata[70:64]),
        .i_queue_full (q_full),
        .o_ready      (o_s_axis_tready),
        .o_push       (front_push),
        .o_run        (front_run),
        .o_total      (front_total)
    );

    assign q_in = {front_total, front_run};

    mfbp_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign head_run   = q_out[RUN_W-1:0];
    assign head_total = q_out[ENTRY_W-1:RUN_W];

    // back: sends the bytes of the head run one per cycle while the receiver is ready
    mfbp_back #(
        .BIT_COUNT_WIDTH (BIT_COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run        (head_run),
        .i_total      (head_total),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (out_byte),
        .o_bits       (out_bits),
        .o_byte_valid (out_byte_valid),
        .o_last       (o_m_axis_tlast),
        .o_end        (out_end)
    );

    assign o_m_axis_tdata = {out_bits, out_byte};
    assign o_m_axis_tuser = {out_end, out_byte_valid};

endmodule
`default_nettype wire

/* hdl/mfbp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module mfbp_front #(
    parameter int MAX_FIELD_BITS  = 64,
    parameter int BIT_COUNT_WIDTH = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wire  [mfbp_pkg::OP_W-1:0]            i_op,
    input  wire  [mfbp_pkg::WORD_W-1:0]          i_value,
    input  wire  [mfbp_pkg::WIDTH_W-1:0]         i_width,
    input  wire                                  i_queue_full,
    output logic                                 o_ready,
    output logic                                 o_push,
    output mfbp_pkg::t_run                       o_run,
    output logic [BIT_COUNT_WIDTH-1:0]           o_total
);

    localparam int TW1 = BIT_COUNT_WIDTH + 1;
    localparam logic [mfbp_pkg::WIDTH_W-1:0] MAXW = mfbp_pkg::WIDTH_W'(MAX_FIELD_BITS);

    logic [mfbp_pkg::PEND_W-1:0]    r_pend, n_pend;
    logic [mfbp_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [BIT_COUNT_WIDTH-1:0]     r_total, n_total;

    logic                           accept;
    logic [mfbp_pkg::WIDTH_W-1:0]   wc;
    logic [mfbp_pkg::WORD_W-1:0]    val_m;
    logic [mfbp_pkg::ACC_W-1:0]     acc;
    logic [mfbp_pkg::ACC_W-1:0]     sh;
    logic [mfbp_pkg::WIDTH_W-1:0]   len;
    logic [mfbp_pkg::CNT_W-1:0]     rem;
    logic [mfbp_pkg::PEND_W-1:0]    pend_w;
    logic [mfbp_pkg::NB_W-1:0]      pad;
    logic [mfbp_pkg::BYTE_W-1:0]    pad_byte;
    logic [TW1-1:0]                 sum_field, sum_pad;
    logic [BIT_COUNT_WIDTH-1:0]     sat_field, sat_pad;
    logic                           has_pend;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        wc    = (i_width > MAXW) ? MAXW : i_width;
        val_m = i_value & ~({mfbp_pkg::WORD_W{1'b1}} << wc);
        // pending bits followed by the new field bits
        acc   = ({{mfbp_pkg::WORD_W{1'b0}}, r_pend} << wc)
              | {{mfbp_pkg::PEND_W{1'b0}}, val_m};
        len   = {{(mfbp_pkg::WIDTH_W-mfbp_pkg::CNT_W){1'b0}}, r_cnt} + wc;
        rem   = len[mfbp_pkg::CNT_W-1:0];
        sh    = acc >> rem;
        pend_w = acc[mfbp_pkg::PEND_W-1:0] & ~({mfbp_pkg::PEND_W{1'b1}} << rem);
        has_pend = (r_cnt != '0);
        pad   = mfbp_pkg::NB_W'(mfbp_pkg::BYTE_W) - {1'b0, r_cnt};
        pad_byte = {1'b0, r_pend} << pad;
        sum_field = {1'b0, r_total} + TW1'(wc);
        sum_pad   = {1'b0, r_total} + TW1'(pad);
        sat_field = sum_field[BIT_COUNT_WIDTH] ? '1 : sum_field[BIT_COUNT_WIDTH-1:0];
        sat_pad   = sum_pad[BIT_COUNT_WIDTH] ? '1 : sum_pad[BIT_COUNT_WIDTH-1:0];
    end

    always_comb begin
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        n_total = r_total;
        o_push  = 1'b0;
        o_run.word        = {{(mfbp_pkg::WORD_W-mfbp_pkg::BYTE_W){1'b0}}, pad_byte};
        o_run.n_bytes     = mfbp_pkg::NB_W'(1);
        o_run.byte_valid  = 1'b1;
        o_run.message_end = 1'b0;
        o_total           = sat_pad;
        case (i_op)
            mfbp_pkg::OP_WRITE: begin
                n_pend  = pend_w;
                n_cnt   = rem;
                n_total = sat_field;
                o_run.word    = sh[mfbp_pkg::WORD_W-1:0];
                o_run.n_bytes = len[mfbp_pkg::WIDTH_W-1:mfbp_pkg::CNT_W];
                o_push  = accept && (len[mfbp_pkg::WIDTH_W-1:mfbp_pkg::CNT_W] != '0);
            end
            mfbp_pkg::OP_ALIGN: begin
                if (has_pend) begin
                    n_pend  = '0;
                    n_cnt   = '0;
                    n_total = sat_pad;
                    o_push  = accept;
                end
            end
            mfbp_pkg::OP_FINISH: begin
                n_pend  = '0;
                n_cnt   = '0;
                n_total = '0;
                o_push  = accept;
                o_run.message_end = 1'b1;
                if (!has_pend) begin
                    o_run.word       = '0;
                    o_run.byte_valid = 1'b0;
                    o_total          = r_total;
                end
            end
            default: begin
                // unused code, nothing changes
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_cnt   <= '0;
            r_total <= '0;
        end else if (accept) begin
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_total <= n_total;
        end
    end

endmodule
`default_nettype wire

/* hdl/mfbp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module mfbp_queue #(
    parameter int DATA_W = 102
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    input  wire               i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic              o_full
);

    // two entry queue
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_count;

    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* hdl/mfbp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module mfbp_back #(
    parameter int BIT_COUNT_WIDTH = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  mfbp_pkg::t_run                 i_run,
    input  wire  [BIT_COUNT_WIDTH-1:0]           i_total,
    input  wire                                  i_empty,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [mfbp_pkg::BYTE_W-1:0]          o_byte,
    output logic [mfbp_pkg::OUT_TOTAL_W-1:0]     o_bits,
    output logic                                 o_byte_valid,
    output logic                                 o_last,
    output logic                                 o_end
);

    localparam int TW1 = BIT_COUNT_WIDTH + 1;

    logic [mfbp_pkg::CNT_W-1:0]   r_idx;
    logic [BIT_COUNT_WIDTH-1:0]   r_tot;

    logic                         fire;
    logic                         last;
    logic [mfbp_pkg::NB_W-1:0]    pos_full;
    logic [mfbp_pkg::CNT_W-1:0]   pos;
    logic [BIT_COUNT_WIDTH-1:0]   cur_total;
    logic [TW1-1:0]               next_sum;
    logic [BIT_COUNT_WIDTH+mfbp_pkg::OUT_TOTAL_W-1:0] total_ext;

    always_comb begin
        fire      = (!o_valid || i_ready) && !i_empty;
        last      = ({1'b0, r_idx} == (i_run.n_bytes - mfbp_pkg::NB_W'(1)));
        pos_full  = i_run.n_bytes - mfbp_pkg::NB_W'(1) - {1'b0, r_idx};
        pos       = pos_full[mfbp_pkg::CNT_W-1:0];
        cur_total = (r_idx == '0) ? i_total : r_tot;
        next_sum  = {1'b0, cur_total} + TW1'(mfbp_pkg::BYTE_W);
        total_ext = {{mfbp_pkg::OUT_TOTAL_W{1'b0}}, cur_total};
        o_pop     = fire && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_idx   <= '0;
        end else if (fire) begin
            o_valid <= 1'b1;
            r_idx   <= last ? '0 : r_idx + mfbp_pkg::CNT_W'(1);
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    // output payload and running total
    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_byte       <= i_run.word[{pos, 3'b000} +: mfbp_pkg::BYTE_W];
            o_bits       <= total_ext[mfbp_pkg::OUT_TOTAL_W-1:0];
            o_byte_valid <= i_run.byte_valid;
            o_last       <= last;
            o_end        <= i_run.message_end;
            r_tot        <= next_sum[BIT_COUNT_WIDTH] ? '1 : next_sum[BIT_COUNT_WIDTH-1:0];
        end
    end

endmodule
`default_nettype wire

/* bench/mfbp_checker.sv */
`timescale 1ns / 1ps
// watches both streams of the bit packer, predicts the result items of every
// accepted input item and compares them in order against the output stream
module mfbp_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    input  wire        i_s_tready,
    input  wire [71:0] i_s_tdata,     // value [63:0], field_width [70:64], zero [71]
    input  wire [1:0]  i_s_tuser,     // operation [1:0]
    input  wire        i_m_tvalid,
    input  wire        i_m_tready,
    input  wire [39:0] i_m_tdata,     // data_byte [7:0], bits_written [39:8]
    input  wire [1:0]  i_m_tuser,     // byte_valid [0], message_end [1]
    input  wire        i_m_tlast,     // last_in_run
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam int FIELD_BITS_MAX = 64;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last_in_run;
        logic        message_end;
        logic [31:0] bits_written;
    } t_out_byte;

    t_out_byte   expected_bytes[$];
    logic [6:0]  part_bits;
    logic [2:0]  part_cnt;
    logic [31:0] stream_bits;

    // running bit offset saturates at all ones
    task automatic bump_total(input int n);
        if ({1'b0, stream_bits} + 33'(n) > 33'h0_FFFF_FFFF) begin
            stream_bits = '1;
        end else begin
            stream_bits = stream_bits + 32'(n);
        end
    endtask

    task automatic expect_byte(input logic [7:0] b, input logic valid, input logic last,
                               input logic fin);
        t_out_byte r;
        r.data_byte    = b;
        r.byte_valid   = valid;
        r.last_in_run  = last;
        r.message_end  = fin;
        r.bits_written = stream_bits;
        expected_bytes.push_back(r);
    endtask

    // zero-fill the partial byte, first written bit ends up in bit 7
    task automatic pad_partial(output logic [7:0] b);
        b = {1'b0, part_bits} << (8 - int'(part_cnt));
        bump_total(8 - int'(part_cnt));
        part_bits = '0;
        part_cnt  = '0;
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [63:0] value,
                                input logic [6:0] width);
        int        w;
        int        first_new;
        logic [7:0] acc;
        logic [7:0] b;
        t_out_byte tail;
        case (op)
            mfbp_pkg::OP_WRITE: begin
                w = (int'(width) > FIELD_BITS_MAX) ? FIELD_BITS_MAX : int'(width);
                first_new = expected_bytes.size();
                for (int i = w; i > 0; i--) begin
                    acc = {part_bits, value[i-1]};
                    bump_total(1);
                    if (part_cnt == 3'd7) begin
                        expect_byte(acc, 1'b1, 1'b0, 1'b0);
                        part_bits = '0;
                        part_cnt  = '0;
                    end else begin
                        part_bits = acc[6:0];
                        part_cnt  = part_cnt + 3'd1;
                    end
                end
                if (expected_bytes.size() > first_new) begin
                    tail = expected_bytes.pop_back();
                    tail.last_in_run = 1'b1;
                    expected_bytes.push_back(tail);
                end
            end
            mfbp_pkg::OP_ALIGN: begin
                if (part_cnt != 3'd0) begin
                    pad_partial(b);
                    expect_byte(b, 1'b1, 1'b1, 1'b0);
                end
            end
            mfbp_pkg::OP_FINISH: begin
                if (part_cnt == 3'd0) begin
                    expect_byte(8'h00, 1'b0, 1'b1, 1'b1);
                end else begin
                    pad_partial(b);
                    expect_byte(b, 1'b1, 1'b1, 1'b1);
                end
                part_bits   = '0;
                part_cnt    = '0;
                stream_bits = '0;
            end
            default: begin
                // unused code, dropped by the block
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_byte got;
        t_out_byte want;
        if (!i_rst_n) begin
            part_bits    = '0;
            part_cnt     = '0;
            stream_bits  = '0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_bytes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.data_byte    = i_m_tdata[7:0];
                got.bits_written = i_m_tdata[39:8];
                got.byte_valid   = i_m_tuser[0];
                got.message_end  = i_m_tuser[1];
                got.last_in_run  = i_m_tlast;
                if (expected_bytes.size() == 0) begin
                    $display("%0t unexpected result: exp none got %02h/%0b/%0b/%0b/%0d",
                             $time, got.data_byte, got.byte_valid, got.last_in_run,
                             got.message_end, got.bits_written);
                    o_fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    o_checked++;
                    // fields shown as byte/valid/last/end/bits
                    if (got.data_byte !== want.data_byte ||
                        got.byte_valid !== want.byte_valid ||
                        got.last_in_run !== want.last_in_run ||
                        got.message_end !== want.message_end ||
                        got.bits_written !== want.bits_written) begin
                        $display("%0t bad result: exp %02h/%0b/%0b/%0b/%0d got %02h/%0b/%0b/%0b/%0d",
                                 $time, want.data_byte, want.byte_valid, want.last_in_run,
                                 want.message_end, want.bits_written, got.data_byte,
                                 got.byte_valid, got.last_in_run, got.message_end,
                                 got.bits_written);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_item(i_s_tuser, i_s_tdata[63:0], i_s_tdata[70:64]);
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// top of the bench: clock, reset, stimulus, output back-pressure, watchdog and
// the verdict; all prediction and comparison lives in the checker
module tb;

    // code the block has no use for, must be dropped without a result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 345;
    localparam int STALL_LIMIT   = 2000;   // cycles with no handshake on either side
    localparam int HOLD_START    = 60;     // receiver hold-off, in receiver cycles
    localparam int HOLD_LEN      = 300;
    localparam int RX_CALM_START = 700;    // receiver always ready in this window
    localparam int RX_CALM_END   = 1000;
    localparam int TX_CALM_START = 150;    // sender never idles for these items
    localparam int TX_CALM_END   = 220;
    localparam int MID_DRAIN_AT  = 260;    // sender waits for all results here

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [71:0] s_data  = '0;             // value [63:0], field_width [70:64], zero [71]
    logic [1:0]  s_user  = mfbp_pkg::OP_WRITE; // operation [1:0]
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;                   // data_byte [7:0], bits_written [39:8]
    logic [1:0]  m_user;                   // byte_valid [0], message_end [1]
    logic        m_last;                   // last_in_run

    int fail_count;
    int pending;
    int checked;

    // stimulus bookkeeping
    logic random_phase = 1'b0;
    int   n_random     = 0;
    int   n_writes     = 0;
    int   n_aligns     = 0;
    int   n_finishes   = 0;
    int   n_ignored    = 0;
    int   rx_cycles    = 0;
    int   stall_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    msb_first_bit_packer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    mfbp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .i_m_tlast    (m_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // output side: random back-pressure, one long hold-off once the random part
    // runs so the run queue fills and the input stalls, then a calm stretch
    always @(negedge i_clk) begin
        if (random_phase) begin
            rx_cycles <= rx_cycles + 1;
        end
        if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
            m_ready <= 1'b0;
        end else if (rx_cycles >= RX_CALM_START && rx_cycles < RX_CALM_END) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 29);
        end
    end

    // watchdog: ends the run if nothing moves on either stream for too long
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one item from a falling edge and hold it until taken; random idle
    // cycles go in front of it except during the sender's calm stretch
    task automatic send_item(input logic [1:0] op, input logic [63:0] value,
                             input logic [6:0] width);
        bit calm;
        calm = random_phase && n_random >= TX_CALM_START && n_random < TX_CALM_END;
        while (!calm && $urandom_range(0, 99) < 29) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = {1'b0, width, value};
        s_user  = op;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        case (op)
            mfbp_pkg::OP_WRITE:  n_writes++;
            mfbp_pkg::OP_ALIGN:  n_aligns++;
            mfbp_pkg::OP_FINISH: n_finishes++;
            default:             n_ignored++;
        endcase
        if (random_phase && op != OP_UNUSED) begin
            n_random++;
        end
    endtask

    // sender stops offering until every predicted result has come out
    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // mostly short fields, some long ones, a few empty and a few over the limit
    function automatic logic [6:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 7'd0;
        if (r < 70) return 7'($urandom_range(1, 16));
        if (r < 85) return 7'($urandom_range(17, 63));
        if (r < 93) return 7'd64;
        return 7'($urandom_range(65, 127));
    endfunction

    initial begin
        int n_fields;
        int r;
        bit mid_drained;
        mid_drained = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part
        send_item(mfbp_pkg::OP_WRITE,  64'h0, 7'd0);       // empty field
        send_item(mfbp_pkg::OP_FINISH, 64'h0, 7'd0);       // finish with nothing written
        send_item(mfbp_pkg::OP_WRITE,  '1, 7'd1);
        send_item(mfbp_pkg::OP_ALIGN,  '1, 7'd127);        // pad a single pending bit
        send_item(mfbp_pkg::OP_ALIGN,  64'h0, 7'd0);       // nothing pending, no result
        send_item(mfbp_pkg::OP_WRITE,  64'h5, 7'd3);
        send_item(mfbp_pkg::OP_WRITE,  '1, 7'd64);         // full field, eight bytes
        send_item(mfbp_pkg::OP_WRITE,  64'h0, 7'd64);
        send_item(mfbp_pkg::OP_WRITE,  64'hA5A5_A5A5_A5A5_A5A5, 7'd7);
        send_item(mfbp_pkg::OP_FINISH, '1, 7'd64);         // finish pads pending bits
        send_item(mfbp_pkg::OP_WRITE,  '1, 7'd127);        // over-wide field gets clamped
        send_item(mfbp_pkg::OP_WRITE,  64'h0123, 7'd65);
        send_item(mfbp_pkg::OP_WRITE,  64'hAB, 7'd8);
        send_item(OP_UNUSED, '1, 7'd127);                  // unused code, ignored
        send_item(mfbp_pkg::OP_WRITE,  64'h7F, 7'd7);
        send_item(mfbp_pkg::OP_WRITE,  64'h1, 7'd1);       // completes a byte exactly
        send_item(mfbp_pkg::OP_FINISH, 64'h0, 7'd0);       // empty finish, nonzero total
        send_item(mfbp_pkg::OP_WRITE,  64'h8000_0000_0000_0000, 7'd64);
        send_item(mfbp_pkg::OP_WRITE,  64'h3, 7'd2);
        send_item(mfbp_pkg::OP_ALIGN,  64'h0, 7'd0);
        send_item(mfbp_pkg::OP_WRITE,  64'h6, 7'd3);
        send_item(OP_UNUSED, 64'h0, 7'd0);
        send_item(mfbp_pkg::OP_FINISH, 64'h0, 7'd0);
        wait_drained();

        // random part: messages of a few fields closed by a finish, with stray
        // aligns, early finishes, unused codes and unterminated messages mixed in
        random_phase = 1'b1;
        while (n_random < RANDOM_ITEMS) begin
            n_fields = $urandom_range(1, 10);
            for (int k = 0; k < n_fields; k++) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_item(mfbp_pkg::OP_WRITE, rand_word(), pick_width());
                end else if (r < 92) begin
                    send_item(mfbp_pkg::OP_ALIGN, rand_word(), 7'($urandom_range(0, 127)));
                end else if (r < 97) begin
                    send_item(mfbp_pkg::OP_FINISH, rand_word(), 7'($urandom_range(0, 127)));
                end else begin
                    send_item(OP_UNUSED, rand_word(), 7'($urandom_range(0, 127)));
                end
            end
            if ($urandom_range(0, 9) != 0) begin
                send_item(mfbp_pkg::OP_FINISH, rand_word(), 7'($urandom_range(0, 127)));
            end
            if (!mid_drained && n_random >= MID_DRAIN_AT) begin
                wait_drained();
                mid_drained = 1'b1;
            end
        end

        // let the queue empty, then a short tail for anything stray
        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("run: %0d writes, %0d aligns, %0d finishes, %0d unused codes sent",
                 n_writes, n_aligns, n_finishes, n_ignored);
        $display("run: %0d results checked, output held off %0d cycles once",
                 checked, HOLD_LEN);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/mfbp_pkg.sv
hdl/mfbp_front.sv
hdl/mfbp_queue.sv
hdl/mfbp_back.sv
hdl/msb_first_bit_packer_top.sv
bench/mfbp_checker.sv
bench/tb.sv
